/* rtl/core/kme_pkg.sv */
`timescale 1ns / 1ps

package kme_pkg;

	// Matrix size limits and defaults
	localparam int MAX_COLS         = 9;
	localparam int MAX_ROWS         = 10;
	localparam int NUM_COLUMNS_DEF  = 9;
	localparam int NUM_ROWS_DEF     = 10;

	// Key index wide enough for the largest matrix (90 keys)
	localparam int IDX_W            = 7;
	localparam int CODE_W           = 9;
	localparam int READ_W           = 16;

	// Code layout
	localparam logic [IDX_W-1:0]  LOW_LIMIT  = 7'd63;
	localparam logic [IDX_W-1:0]  HIGH_BASE  = 7'd64;
	localparam logic [CODE_W-1:0] HIGH_BIT   = 9'h100;
	localparam int                SHIFT_POS  = 6;
	localparam int                CTRL_POS   = 7;
	localparam logic [READ_W-1:0] NO_CODE    = 16'hFFFF;

	// Request kinds carried on tuser
	localparam logic REQ_SCAN = 1'b0;
	localparam logic REQ_READ = 1'b1;

	// Stream packing
	localparam int IN_W      = MAX_COLS * MAX_ROWS + 2;
	localparam int S_DATA_W  = ((IN_W + 7) / 8) * 8;
	localparam int SHIFT_BIT = MAX_COLS * MAX_ROWS;
	localparam int CTRL_BIT  = MAX_COLS * MAX_ROWS + 1;
	localparam int OUT_W     = READ_W + 2;
	localparam int M_DATA_W  = ((OUT_W + 7) / 8) * 8;

	typedef logic [MAX_COLS-1:0][MAX_ROWS-1:0] col_words_t;

	typedef struct packed {
		logic              hit;
		logic              down;
		logic [CODE_W-1:0] code;
	} scan_res_t;

	typedef struct packed {
		logic              code_valid;
		logic [CODE_W-1:0] held_code;
	} held_t;

	typedef struct packed {
		logic              any_key;
		logic              data_ready;
		logic [READ_W-1:0] read_code;
	} result_t;

	// Code of a key index without the shift and control bits
	function automatic logic [CODE_W-1:0] key_base(input logic [IDX_W-1:0] idx);
		logic [IDX_W-1:0] rel;
		rel = idx - HIGH_BASE;
		if (idx > LOW_LIMIT) begin
			return HIGH_BIT | {3'b000, rel[5:0]};
		end else begin
			return {3'b000, idx[5:0]};
		end
	endfunction

endpackage

/* rtl/core/kme_scan.sv */
`timescale 1ns / 1ps

module kme_scan #(
	parameter int NUM_COLUMNS = kme_pkg::NUM_COLUMNS_DEF,
	parameter int NUM_ROWS    = kme_pkg::NUM_ROWS_DEF
) (
	input  kme_pkg::col_words_t cols,
	input  logic                shift_level,
	input  logic                control_level,
	input  kme_pkg::held_t      held,
	output kme_pkg::scan_res_t  res
);
	import kme_pkg::*;

	localparam int NUM_KEYS = NUM_COLUMNS * NUM_ROWS;

	logic [NUM_KEYS-1:0] pressed;
	logic [NUM_KEYS-1:0] cand;
	logic [NUM_KEYS-1:0] first;
	logic [CODE_W-1:0]   mods;
	logic [CODE_W-1:0]   code_or;

	assign mods = (CODE_W'(shift_level) << SHIFT_POS) | (CODE_W'(control_level) << CTRL_POS);

	// A key is a candidate when pressed and its code is not the held one
	always_comb begin
		for (int c = 0; c < NUM_COLUMNS; c++) begin
			for (int r = 0; r < NUM_ROWS; r++) begin
				pressed[c*NUM_ROWS + r] = cols[c][r];
				cand[c*NUM_ROWS + r]    = cols[c][r] && !(held.code_valid &&
					((key_base(IDX_W'(c*NUM_ROWS + r)) | mods) == held.held_code));
			end
		end
	end

	// Isolate the first candidate in scan order
	assign first = cand & (~cand + NUM_KEYS'(1));

	always_comb begin
		code_or = '0;
		for (int i = 0; i < NUM_KEYS; i++) begin
			if (first[i]) begin
				code_or = code_or | key_base(IDX_W'(i));
			end
		end
	end

	assign res.hit  = |cand;
	assign res.down = |pressed;
	assign res.code = code_or | mods;

endmodule

/* rtl/core/kme_state.sv */
`timescale 1ns / 1ps

module kme_state (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  logic               req_type,
	input  kme_pkg::scan_res_t scan,
	output kme_pkg::held_t     held,
	output kme_pkg::result_t   result
);
	import kme_pkg::*;

	logic [CODE_W-1:0] held_code_q, held_code_d;
	logic              code_valid_q, code_valid_d;
	logic              ready_q, ready_d;
	logic              any_q, any_d;
	logic [READ_W-1:0] read_code;

	always_comb begin
		held_code_d  = held_code_q;
		code_valid_d = code_valid_q;
		ready_d      = ready_q;
		any_d        = any_q;
		read_code    = '0;
		if (req_type == REQ_READ) begin
			read_code = code_valid_q ? READ_W'(held_code_q) : NO_CODE;
			ready_d   = 1'b0;
		end else if (scan.hit) begin
			// latch the new key, leave any-key untouched
			held_code_d  = scan.code;
			code_valid_d = 1'b1;
			ready_d      = 1'b1;
		end else begin
			if (!scan.down) begin
				held_code_d  = '0;
				code_valid_d = 1'b0;
			end
			any_d = scan.down;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_code_q  <= '0;
			code_valid_q <= 1'b0;
			ready_q      <= 1'b0;
			any_q        <= 1'b0;
		end else if (advance) begin
			held_code_q  <= held_code_d;
			code_valid_q <= code_valid_d;
			ready_q      <= ready_d;
			any_q        <= any_d;
		end
	end

	assign held.held_code  = held_code_q;
	assign held.code_valid = code_valid_q;

	assign result.read_code  = read_code;
	assign result.data_ready = ready_d;
	assign result.any_key    = any_d;

endmodule

/* rtl/core/keyboard_matrix_encoder_top.sv */
`timescale 1ns / 1ps
// Flow: a taken input beat waits in the input register while the output
// register holds a stalled beat; its result is then registered and offered.
// Throughput: one beat per cycle with m_tready high; the input register feeds
// the key search and state update, whose result lands in the output register.
// Reset: arst_n clears both valid stages, the held code and the data-ready
// and any-key flags.

module keyboard_matrix_encoder_top #(
	parameter int NUM_COLUMNS = kme_pkg::NUM_COLUMNS_DEF,
	parameter int NUM_ROWS    = kme_pkg::NUM_ROWS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// col0..col8 (10 bits each), shift_level, control_level, zero fill
	input  logic [kme_pkg::S_DATA_W-1:0]  s_tdata,
	// req_type
	input  logic [0:0]                    s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// read_code (16), data_ready, any_key, zero fill
	output logic [kme_pkg::M_DATA_W-1:0]  m_tdata
);
	import kme_pkg::*;

	logic              valid_s1;
	logic [IN_W-1:0]   data_s1;
	logic              req_s1;
	logic              valid_s2;
	result_t           res_s2;

	logic              s_fire;
	logic              advance;
	col_words_t        cols;
	held_t             held;
	scan_res_t         scan;
	result_t           result;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign s_fire   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_fire) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			data_s1 <= s_tdata[IN_W-1:0];
			req_s1  <= s_tuser[0];
		end
		if (advance) begin
			res_s2 <= result;
		end
	end

	assign cols = col_words_t'(data_s1[MAX_COLS*MAX_ROWS-1:0]);

	kme_scan #(
		.NUM_COLUMNS (NUM_COLUMNS),
		.NUM_ROWS    (NUM_ROWS)
	) u_scan (
		.cols          (cols),
		.shift_level   (data_s1[SHIFT_BIT]),
		.control_level (data_s1[CTRL_BIT]),
		.held          (held),
		.res           (scan)
	);

	kme_state u_state (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.req_type (req_s1),
		.scan     (scan),
		.held     (held),
		.result   (result)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {(M_DATA_W - OUT_W)'(0), res_s2.any_key, res_s2.data_ready,
		res_s2.read_code};

endmodule

/* rtl/core/kme_checker.sv */
`timescale 1ns / 1ps

module kme_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [kme_pkg::M_DATA_W-1:0] m_tdata
);
	import kme_pkg::*;

	logic [1:0] inflight_q;
	logic       s_fire;
	logic       m_fire;

	assign s_fire = s_tvalid && s_tready;
	assign m_fire = m_tvalid && m_tready;

	// Count beats taken but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + 2'(s_fire) - 2'(m_fire);
		end
	end

	a_reset_quiet: assert property (@(posedge clk) $rose(arst_n) |-> !m_tvalid)
		else $error("result beat offered right out of reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result beat changed");

	a_inflight_max: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q != 2'd3)
		else $error("more beats in flight than stages");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> inflight_q != 2'd0)
		else $error("result beat without a taken input beat");

	a_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[READ_W-1:0] == NO_CODE |-> !m_tdata[READ_W])
		else $error("read result left data-ready set");

endmodule

bind keyboard_matrix_encoder_top kme_checker u_kme_checker (.*);

/* sim/keyboard_matrix_encoder_checker.sv */
`timescale 1ns / 1ps

module keyboard_matrix_encoder_checker #(
	parameter int NUM_COLUMNS = kme_pkg::NUM_COLUMNS_DEF,
	parameter int NUM_ROWS    = kme_pkg::NUM_ROWS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	input  logic                         s_tready,
	// col0..col8 (10 bits each), shift_level, control_level, zero fill
	input  logic [kme_pkg::S_DATA_W-1:0] s_tdata,
	// req_type
	input  logic [0:0]                   s_tuser,
	input  logic                         m_tvalid,
	input  logic                         m_tready,
	// read_code (16), data_ready, any_key, zero fill
	input  logic [kme_pkg::M_DATA_W-1:0] m_tdata,
	output int                           fail_count,
	output int                           pending,
	output int                           checked,
	output int                           latched
);
	import kme_pkg::*;

	logic [CODE_W-1:0] kb_code;
	logic              kb_valid;
	logic              kb_ready;
	logic              kb_any;
	result_t           expected_q[$];
	int                mismatches;
	int                beats_out;
	int                latch_count;

	task automatic report_mismatch(input string what, input int unsigned got_v,
			input int unsigned want_v);
		mismatches++;
		$display("%0t: mismatch on result beat %0d: %s got %h expected %h",
			$realtime, beats_out, what, got_v, want_v);
	endtask

	// Advance the encoder state by one beat and return the result it should give.
	function automatic result_t encode_beat(input logic req,
			input logic [S_DATA_W-1:0] data);
		col_words_t        cols;
		logic              shift_lv;
		logic              ctrl_lv;
		logic              down;
		logic              hit;
		logic [CODE_W-1:0] code;
		int                idx;
		result_t           res;
		cols     = col_words_t'(data[MAX_COLS*MAX_ROWS-1:0]);
		shift_lv = data[SHIFT_BIT];
		ctrl_lv  = data[CTRL_BIT];
		res      = '0;
		if (req == REQ_READ) begin
			res.read_code = kb_valid ? READ_W'(kb_code) : NO_CODE;
			kb_ready = 1'b0;
		end else begin
			down = 1'b0;
			hit  = 1'b0;
			// Visit column by column, row 0 first; stop at the first new code.
			for (int x = 0; x < NUM_COLUMNS; x++) begin
				for (int y = 0; y < NUM_ROWS; y++) begin
					if (!hit && cols[x][y]) begin
						idx = x * NUM_ROWS + y;
						if (idx > 63) begin
							code = {3'b100, 6'(idx - 64)};
						end else begin
							code = {3'b000, 6'(idx)};
						end
						code[SHIFT_POS] = shift_lv;
						code[CTRL_POS]  = ctrl_lv;
						down = 1'b1;
						if (!kb_valid || kb_code != code) begin
							kb_code  = code;
							kb_valid = 1'b1;
							kb_ready = 1'b1;
							hit      = 1'b1;
							latch_count++;
						end
					end
				end
			end
			if (!hit) begin
				if (!down) begin
					kb_valid = 1'b0;
					kb_code  = '0;
				end
				kb_any = down;
			end
		end
		res.data_ready = kb_ready;
		res.any_key    = kb_any;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		result_t got;
		result_t want;
		if (!arst_n) begin
			kb_code     = '0;
			kb_valid    = 1'b0;
			kb_ready    = 1'b0;
			kb_any      = 1'b0;
			mismatches  = 0;
			beats_out   = 0;
			latch_count = 0;
			expected_q.delete();
			fail_count <= 0;
			pending    <= 0;
			checked    <= 0;
			latched    <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata[OUT_W-1:0]);
				if (expected_q.size() == 0) begin
					report_mismatch("result with nothing expected", 32'(got), 0);
				end else begin
					want = expected_q.pop_front();
					if (got.read_code != want.read_code)
						report_mismatch("read_code", 32'(got.read_code),
							32'(want.read_code));
					if (got.data_ready != want.data_ready)
						report_mismatch("data_ready", 32'(got.data_ready),
							32'(want.data_ready));
					if (got.any_key != want.any_key)
						report_mismatch("any_key", 32'(got.any_key), 32'(want.any_key));
				end
				beats_out++;
			end
			if (s_tvalid && s_tready)
				expected_q.push_back(encode_beat(s_tuser[0], s_tdata));
			fail_count <= mismatches;
			pending    <= expected_q.size();
			checked    <= beats_out;
			latched    <= latch_count;
		end
	end

	final begin
		if (expected_q.size() != 0)
			$display("%0d results never arrived", expected_q.size());
	end

endmodule

/* sim/keyboard_matrix_encoder_top_tb.sv */
`timescale 1ns / 1ps

module keyboard_matrix_encoder_top_tb;
	import kme_pkg::*;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic [0:0]          s_tuser;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;

	int   fail_count;
	int   pending;
	int   checked;
	int   latched;
	int   scans;
	int   reads;
	logic calm;

	keyboard_matrix_encoder_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	keyboard_matrix_encoder_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked),
		.latched    (latched)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Stall the result side at random outside the calm stretch.
	always @(posedge clk) begin
		m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 9);
	end

	function automatic col_words_t one_key(input int col, input int row);
		col_words_t c;
		c           = '0;
		c[col][row] = 1'b1;
		return c;
	endfunction

	function automatic col_words_t noise_cols();
		col_words_t c;
		for (int x = 0; x < MAX_COLS; x++)
			c[x] = MAX_ROWS'($urandom);
		return c;
	endfunction

	task automatic send_beat(input logic req, input col_words_t cols, input logic sh,
			input logic ct);
		if (!calm) begin
			while ($urandom_range(99) < 9) begin
				s_tvalid <= 1'b0;
				@(posedge clk);
			end
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {{(S_DATA_W - IN_W){1'b0}}, ct, sh, cols};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		if (req == REQ_READ)
			reads++;
		else
			scans++;
	endtask

	// Hold the input side until every predicted result is back.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		col_words_t held;
		logic       sh;
		logic       ct;
		int         pick;
		int         x;
		int         y;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= REQ_SCAN;
		calm     = 1'b0;
		scans    = 0;
		reads    = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: read before any scan, latching, held keys, code range edges.
		send_beat(REQ_READ, '0, 1'b0, 1'b0);
		send_beat(REQ_SCAN, '0, 1'b0, 1'b0);
		send_beat(REQ_SCAN, one_key(0, 0), 1'b0, 1'b0);
		send_beat(REQ_READ, '0, 1'b0, 1'b0);
		send_beat(REQ_SCAN, one_key(0, 0), 1'b0, 1'b0);
		send_beat(REQ_SCAN, one_key(0, 0) | one_key(0, 1), 1'b0, 1'b0);
		send_beat(REQ_SCAN, one_key(6, 3), 1'b1, 1'b0);
		send_beat(REQ_SCAN, one_key(6, 4), 1'b0, 1'b1);
		send_beat(REQ_SCAN, one_key(8, 9), 1'b1, 1'b1);
		send_beat(REQ_READ, '0, 1'b0, 1'b0);
		send_beat(REQ_SCAN, '1, 1'b1, 1'b1);
		send_beat(REQ_SCAN, '1, 1'b1, 1'b1);
		send_beat(REQ_READ, '1, 1'b1, 1'b1);
		send_beat(REQ_SCAN, '0, 1'b1, 1'b1);
		send_beat(REQ_READ, '0, 1'b0, 1'b0);
		send_beat(REQ_SCAN, one_key(8, 0) | one_key(8, 9), 1'b0, 1'b0);
		send_beat(REQ_SCAN, one_key(3, 5), 1'b1, 1'b0);
		send_beat(REQ_SCAN, one_key(3, 5), 1'b1, 1'b0);
		send_beat(REQ_SCAN, one_key(3, 5), 1'b0, 1'b0);
		send_beat(REQ_READ, '0, 1'b0, 1'b0);
		send_beat(REQ_READ, '0, 1'b0, 1'b0);
		send_beat(REQ_SCAN, '0, 1'b0, 1'b0);
		send_beat(REQ_SCAN, '0, 1'b0, 1'b0);
		drain();

		// Random: mostly a few keys pressed and released over repeated scans.
		held = '0;
		sh   = 1'b0;
		ct   = 1'b0;
		for (int n = 0; n < 1800; n++) begin
			calm = (n >= 700 && n < 1000);
			if (n == 1200)
				drain();
			pick = $urandom_range(99);
			if (pick < 12) begin
				send_beat(REQ_READ, noise_cols(), 1'($urandom), 1'($urandom));
			end else if (pick < 20) begin
				send_beat(REQ_SCAN, noise_cols(), 1'($urandom), 1'($urandom));
			end else if (pick < 25) begin
				held = '0;
				send_beat(REQ_SCAN, held, sh, ct);
			end else begin
				if ($urandom_range(2) == 0) begin
					x = $urandom_range(MAX_COLS - 1);
					y = $urandom_range(MAX_ROWS - 1);
					if ($countones(held) > 3)
						held = '0;
					else
						held[x][y] = ~held[x][y];
				end
				if ($urandom_range(9) == 0)
					sh = ~sh;
				if ($urandom_range(9) == 0)
					ct = ~ct;
				send_beat(REQ_SCAN, held, sh, ct);
			end
		end
		calm = 1'b0;
		drain();
		repeat (8) @(posedge clk);

		$display("Covered %0d scan beats and %0d read beats; %0d codes latched,",
			scans, reads, latched);
		$display("%0d result beats compared field by field.", checked);
		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timed out with %0d results outstanding", pending);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
